### rtl/wca_pkg.sv
// ----------------------------------------------------------------------------
// wca_pkg
// Shared types, constants and helpers of the waveform covariance accumulator.
// ----------------------------------------------------------------------------
package wca_pkg;

   localparam int CHANNELS    = 64;
   localparam int SAMPLES     = 32;
   localparam int TETRODES    = 16;
   localparam int CH_W        = $clog2(CHANNELS);
   localparam int SMP_W       = $clog2(SAMPLES);
   localparam int TET_W       = $clog2(TETRODES);
   localparam int SUM_AW      = CH_W + SMP_W;
   localparam int COV_AW      = CH_W + 2 * SMP_W;
   localparam int COUNT_W     = 24;
   localparam int SCALE_W     = 13;
   localparam int MIN_W       = 16;
   localparam int CSR_W       = 16;
   localparam int DIV_W       = 31;
   localparam int DVS_W       = 2 * SCALE_W;
   localparam int DIV_CNT_W   = $clog2(DIV_W);

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic       CMD_ACC  = 1'b0;
   localparam logic       CMD_READ = 1'b1;
   localparam logic [1:0] SEL_COV  = 2'd0;
   localparam logic [1:0] SEL_MEAN = 2'd1;
   localparam logic [1:0] SEL_SQ   = 2'd2;
   localparam logic       REG_SCALE = 1'b0;
   localparam logic       REG_MIN   = 1'b1;

   typedef struct packed {
      logic                command;
      logic [CH_W-1:0]     channel;
      logic [SMP_W-1:0]    row;
      logic [SMP_W-1:0]    col;
      logic signed [15:0]  sample;
      logic                accumulate;
      logic [1:0]          read_select;
      logic [COUNT_W-1:0]  count;
      logic                ready;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef enum logic [3:0] {
      BK_CLEAR, BK_IDLE, BK_RD_REQ, BK_RD_OUT, BK_MEAN_DIV, BK_MEAN_WAIT,
      BK_SQ_MUL, BK_SQ_DIV, BK_SQ_WAIT, BK_COV_RD, BK_COV_MUL, BK_COV_DIV,
      BK_COV_WAIT, BK_DONE
   } back_state_type;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                  input logic signed [31:0] delta);
      logic signed [32:0] sum;
      sum = {acc[31], acc} + {delta[31], delta};
      if (sum[32] != sum[31]) begin
         sat_add = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat_add = sum[31:0];
      end
   endfunction

endpackage

### rtl/wca_divider.sv
// ----------------------------------------------------------------------------
// wca_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wca_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [wca_pkg::DIV_W-1:0]      dividend,
   input  logic [wca_pkg::DVS_W-1:0]      divisor,
   output logic                           done,
   output logic [wca_pkg::DIV_W-1:0]      quotient
);
   logic                            run_ff, run_in;
   logic                            done_ff, done_in;
   logic [wca_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [wca_pkg::DIV_W-1:0]       quo_ff, quo_in;
   logic [wca_pkg::DVS_W-1:0]       rem_ff, rem_in;
   logic [wca_pkg::DVS_W-1:0]       dvs_ff, dvs_in;
   logic [wca_pkg::DVS_W:0]         shifted, trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[wca_pkg::DIV_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = wca_pkg::DIV_CNT_W'(wca_pkg::DIV_W - 1);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         // borrow clear means the divisor fits
         if (!trial[wca_pkg::DVS_W]) begin
            rem_in = trial[wca_pkg::DVS_W-1:0];
         end else begin
            rem_in = shifted[wca_pkg::DVS_W-1:0];
         end
         quo_in = {quo_ff[wca_pkg::DIV_W-2:0], ~trial[wca_pkg::DVS_W]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

### rtl/wca_front.sv
// ----------------------------------------------------------------------------
// wca_front
// Register file, spike counters and classification of incoming commands.
// ----------------------------------------------------------------------------
module wca_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            req_command,
   input  logic [5:0]                      req_channel,
   input  logic [3:0]                      req_tetrode,
   input  logic [4:0]                      req_sample_index,
   input  logic [4:0]                      req_column_index,
   input  logic signed [15:0]              req_sample_value,
   input  logic                            req_accumulate,
   input  logic                            req_spike_end,
   input  logic [1:0]                      req_read_select,
   input  logic                            csr_write_enable,
   input  logic                            csr_index,
   input  logic [wca_pkg::CSR_W-1:0]       csr_write_data,
   output wca_pkg::item_type               item,
   output logic [wca_pkg::SCALE_W-1:0]     scale
);
   logic [wca_pkg::SCALE_W-1:0] scale_ff, scale_in;
   logic [wca_pkg::MIN_W-1:0]   min_ff, min_in;
   logic [wca_pkg::COUNT_W-1:0] counts_ff [wca_pkg::TETRODES];
   logic [wca_pkg::COUNT_W-1:0] count_cur, count_new;
   logic                        bump;

   always_comb begin
      scale_in = scale_ff;
      min_in   = min_ff;
      if (csr_write_enable) begin
         case (csr_index)
            wca_pkg::REG_SCALE: scale_in = csr_write_data[wca_pkg::SCALE_W-1:0];
            wca_pkg::REG_MIN:   min_in   = csr_write_data[wca_pkg::MIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      count_cur = counts_ff[req_tetrode];
      bump      = (req_command == wca_pkg::CMD_ACC) && req_spike_end &&
                  (count_cur != wca_pkg::COUNT_MAX);
      count_new = count_cur + wca_pkg::COUNT_W'(bump);
      item.command     = req_command;
      item.channel     = req_channel;
      item.row         = req_sample_index;
      item.col         = req_column_index;
      item.sample      = req_sample_value;
      item.accumulate  = req_accumulate;
      item.read_select = req_read_select;
      item.count       = count_new;
      item.ready       = count_new >= wca_pkg::COUNT_W'(min_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= wca_pkg::SCALE_W'(1);
         min_ff   <= wca_pkg::MIN_W'(1000);
         for (int i = 0; i < wca_pkg::TETRODES; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         scale_ff <= scale_in;
         min_ff   <= min_in;
         if (accept && bump) begin
            counts_ff[req_tetrode] <= count_new;
         end
      end
   end

   // zero scale behaves as one
   assign scale = (scale_ff == '0) ? wca_pkg::SCALE_W'(1) : scale_ff;
endmodule

### rtl/wca_fifo.sv
// ----------------------------------------------------------------------------
// wca_fifo
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module wca_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wca_pkg::item_type     push_item,
   input  logic                  pop,
   output wca_pkg::item_type     pop_item,
   output wca_pkg::fifo_stat_type stat
);
   wca_pkg::item_type entry_ff [2];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        fill_ff, fill_in;

   always_comb begin
      wr_in   = wr_ff ^ push;
      rd_in   = rd_ff ^ pop;
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

   assign pop_item   = entry_ff[rd_ff];
   assign stat.full  = fill_ff[1];
   assign stat.empty = (fill_ff == '0);
endmodule

### rtl/wca_back.sv
// ----------------------------------------------------------------------------
// wca_back
// Executes commands: accumulator memories, products and the shared divider.
// ----------------------------------------------------------------------------
module wca_back (
   input  logic                            clock,
   input  logic                            reset,
   input  wca_pkg::fifo_stat_type          stat,
   input  wca_pkg::item_type               head,
   input  logic [wca_pkg::SCALE_W-1:0]     scale,
   output logic                            pop,
   output logic                            clearing,
   output logic                            rsp_valid,
   output logic signed [31:0]              rsp_read_value,
   output logic [23:0]                     rsp_spike_count,
   output logic                            rsp_ready_res
);
   wca_pkg::back_state_type state_ff, state_in;
   wca_pkg::item_type       item_ff;
   logic [wca_pkg::SMP_W-1:0]  w_ff;
   logic signed [16:0]         q_ff;
   logic signed [31:0]         prod_ff;
   logic [wca_pkg::DVS_W-1:0]  ss_ff;
   logic                       neg_ff, neg_in;
   logic [wca_pkg::COV_AW-1:0] clr_ff;

   logic                       rsp_valid_ff;
   logic signed [31:0]         rsp_value_ff;
   logic [23:0]                rsp_count_ff;
   logic                       rsp_ready_ff;

   logic signed [15:0]         buf_mem [wca_pkg::SAMPLES];
   logic signed [31:0]         mean_mem [2**wca_pkg::SUM_AW];
   logic signed [31:0]         sq_mem [2**wca_pkg::SUM_AW];
   logic signed [31:0]         cov_mem [2**wca_pkg::COV_AW];
   logic signed [15:0]         buf_rd_ff;
   logic signed [31:0]         mean_rd_ff, sq_rd_ff, cov_rd_ff;

   logic                       sum_we, cov_we;
   logic [wca_pkg::SUM_AW-1:0] sum_addr, sum_waddr;
   logic [wca_pkg::COV_AW-1:0] cov_raddr, cov_waddr;
   logic signed [31:0]         mean_wdata, sq_wdata, cov_wdata;
   logic [wca_pkg::SMP_W-1:0]  lo, hi;

   logic                       div_start, div_done;
   logic [wca_pkg::DIV_W-1:0]  div_dividend, div_quo;
   logic [wca_pkg::DVS_W-1:0]  div_divisor;
   logic signed [31:0]         div_signed, quo_ext, prod_mag;
   logic [16:0]                smp_mag;

   wca_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign quo_ext    = {1'b0, div_quo};
   assign div_signed = neg_ff ? -quo_ext : quo_ext;
   assign prod_mag   = prod_ff[31] ? -prod_ff : prod_ff;
   assign smp_mag    = item_ff.sample[15] ? -{item_ff.sample[15], item_ff.sample} :
                       {item_ff.sample[15], item_ff.sample};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wca_pkg::BK_CLEAR:
            if (clr_ff == '1) state_in = wca_pkg::BK_IDLE;
         wca_pkg::BK_IDLE:
            if (!stat.empty) begin
               if (head.command == wca_pkg::CMD_READ) begin
                  state_in = wca_pkg::BK_RD_REQ;
               end else if (head.accumulate) begin
                  state_in = wca_pkg::BK_MEAN_DIV;
               end else begin
                  state_in = wca_pkg::BK_DONE;
               end
            end
         wca_pkg::BK_RD_REQ:    state_in = wca_pkg::BK_RD_OUT;
         wca_pkg::BK_RD_OUT:    state_in = wca_pkg::BK_IDLE;
         wca_pkg::BK_MEAN_DIV:  state_in = wca_pkg::BK_MEAN_WAIT;
         wca_pkg::BK_MEAN_WAIT:
            if (div_done) state_in = wca_pkg::BK_SQ_MUL;
         wca_pkg::BK_SQ_MUL:    state_in = wca_pkg::BK_SQ_DIV;
         wca_pkg::BK_SQ_DIV:    state_in = wca_pkg::BK_SQ_WAIT;
         wca_pkg::BK_SQ_WAIT:
            if (div_done) state_in = wca_pkg::BK_COV_RD;
         wca_pkg::BK_COV_RD:    state_in = wca_pkg::BK_COV_MUL;
         wca_pkg::BK_COV_MUL:   state_in = wca_pkg::BK_COV_DIV;
         wca_pkg::BK_COV_DIV:   state_in = wca_pkg::BK_COV_WAIT;
         wca_pkg::BK_COV_WAIT:
            if (div_done) begin
               state_in = (w_ff == item_ff.row) ? wca_pkg::BK_DONE : wca_pkg::BK_COV_RD;
            end
         wca_pkg::BK_DONE:      state_in = wca_pkg::BK_IDLE;
         default:               state_in = wca_pkg::BK_IDLE;
      endcase
   end

   // outputs of each state
   always_comb begin
      pop          = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      neg_in       = neg_ff;
      sum_we       = 1'b0;
      cov_we       = 1'b0;
      mean_wdata   = '0;
      sq_wdata     = '0;
      cov_wdata    = '0;
      lo = (item_ff.col < item_ff.row) ? item_ff.col : item_ff.row;
      hi = (item_ff.col < item_ff.row) ? item_ff.row : item_ff.col;
      sum_addr  = {item_ff.channel, item_ff.row};
      sum_waddr = sum_addr;
      cov_raddr = (item_ff.command == wca_pkg::CMD_READ) ?
                  {item_ff.channel, lo, hi} : {item_ff.channel, w_ff, item_ff.row};
      cov_waddr = cov_raddr;
      case (state_ff)
         wca_pkg::BK_CLEAR: begin
            sum_we    = 1'b1;
            cov_we    = 1'b1;
            sum_waddr = clr_ff[wca_pkg::SUM_AW-1:0];
            cov_waddr = clr_ff;
         end
         wca_pkg::BK_IDLE:
            pop = !stat.empty;
         wca_pkg::BK_MEAN_DIV: begin
            div_start    = 1'b1;
            neg_in       = item_ff.sample[15];
            div_dividend = wca_pkg::DIV_W'(smp_mag);
            div_divisor  = wca_pkg::DVS_W'(scale);
         end
         wca_pkg::BK_SQ_DIV, wca_pkg::BK_COV_DIV: begin
            div_start    = 1'b1;
            neg_in       = prod_ff[31];
            div_dividend = prod_mag[wca_pkg::DIV_W-1:0];
            div_divisor  = (state_ff == wca_pkg::BK_SQ_DIV) ?
                           wca_pkg::DVS_W'(scale) : ss_ff;
         end
         wca_pkg::BK_SQ_WAIT: begin
            sum_we     = div_done;
            mean_wdata = wca_pkg::sat_add(mean_rd_ff, 32'(q_ff));
            sq_wdata   = wca_pkg::sat_add(sq_rd_ff, div_signed);
         end
         wca_pkg::BK_COV_WAIT: begin
            cov_we    = div_done;
            cov_wdata = wca_pkg::sat_add(cov_rd_ff, div_signed);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wca_pkg::BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == wca_pkg::BK_RD_OUT) || (state_ff == wca_pkg::BK_DONE);
         if (state_ff == wca_pkg::BK_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
      neg_ff <= neg_in;
      if (pop) begin
         item_ff <= head;
         ss_ff   <= wca_pkg::DVS_W'(scale) * wca_pkg::DVS_W'(scale);
      end
      if (state_ff == wca_pkg::BK_MEAN_WAIT && div_done) begin
         q_ff <= div_signed[16:0];
      end
      if (state_ff == wca_pkg::BK_SQ_MUL) begin
         prod_ff <= 32'(q_ff) * 32'(item_ff.sample);
      end
      if (state_ff == wca_pkg::BK_COV_MUL) begin
         prod_ff <= buf_rd_ff * item_ff.sample;
      end
      if (state_ff == wca_pkg::BK_SQ_WAIT) begin
         w_ff <= '0;
      end else if (state_ff == wca_pkg::BK_COV_WAIT && div_done) begin
         w_ff <= w_ff + 1'b1;
      end
      rsp_count_ff <= item_ff.count;
      rsp_ready_ff <= item_ff.ready;
      if (state_ff == wca_pkg::BK_RD_OUT) begin
         case (item_ff.read_select)
            wca_pkg::SEL_COV:  rsp_value_ff <= cov_rd_ff;
            wca_pkg::SEL_MEAN: rsp_value_ff <= mean_rd_ff;
            wca_pkg::SEL_SQ:   rsp_value_ff <= sq_rd_ff;
            default:           rsp_value_ff <= '0;
         endcase
      end else begin
         rsp_value_ff <= '0;
      end
   end

   // waveform buffer takes every accumulate sample as it is popped
   always_ff @(posedge clock) begin
      if (pop && head.command == wca_pkg::CMD_ACC) begin
         buf_mem[head.row] <= head.sample;
      end
      buf_rd_ff <= buf_mem[w_ff];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         mean_mem[sum_waddr] <= mean_wdata;
      end
      mean_rd_ff <= mean_mem[sum_addr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sq_mem[sum_waddr] <= sq_wdata;
      end
      sq_rd_ff <= sq_mem[sum_addr];
   end

   always_ff @(posedge clock) begin
      if (cov_we) begin
         cov_mem[cov_waddr] <= cov_wdata;
      end
      cov_rd_ff <= cov_mem[cov_raddr];
   end

   assign clearing        = (state_ff == wca_pkg::BK_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_spike_count = rsp_count_ff;
   assign rsp_ready_res   = rsp_ready_ff;
endmodule

### rtl/waveform_covariance_accumulator.sv
// ----------------------------------------------------------------------------
// waveform_covariance_accumulator
// Per-channel mean, square and covariance sums of spike waveforms.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Accumulate commands
// carry one waveform sample; read commands return one accumulator. Every
// command gives one result, shown for one cycle with rsp_valid; the receiver
// cannot hold it off. Results leave in command order.
// Spike counters and ready are settled in the front at the transfer; the
// back works through a two-entry queue, one command at a time.
// An accumulated sample at index r runs through the one shared divider
// r+3 times.
// busy rises when the queue is full.
// After reset a clearing pass zeroes the accumulator memories, one
// covariance entry a cycle; busy stays high throughout. Register writes
// are taken at any time.
// ----------------------------------------------------------------------------
module waveform_covariance_accumulator (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic [5:0]          req_channel,
   input  logic [3:0]          req_tetrode,
   input  logic [4:0]          req_sample_index,
   input  logic [4:0]          req_column_index,
   input  logic signed [15:0]  req_sample_value,
   input  logic                req_accumulate,
   input  logic                req_spike_end,
   input  logic [1:0]          req_read_select,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_read_value,
   output logic [23:0]         rsp_spike_count,
   output logic                rsp_ready_res,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [15:0]         csr_write_data
);
   wca_pkg::item_type           front_item, head_item;
   wca_pkg::fifo_stat_type      stat;
   logic [wca_pkg::SCALE_W-1:0] scale;
   logic                        accept, pop, clearing;

   assign busy   = clearing || stat.full;
   assign accept = start && !busy;

   wca_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_command      (req_command),
      .req_channel      (req_channel),
      .req_tetrode      (req_tetrode),
      .req_sample_index (req_sample_index),
      .req_column_index (req_column_index),
      .req_sample_value (req_sample_value),
      .req_accumulate   (req_accumulate),
      .req_spike_end    (req_spike_end),
      .req_read_select  (req_read_select),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item             (front_item),
      .scale            (scale)
   );

   wca_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (pop),
      .pop_item  (head_item),
      .stat      (stat)
   );

   wca_back u_back (
      .clock           (clock),
      .reset           (reset),
      .stat            (stat),
      .head            (head_item),
      .scale           (scale),
      .pop             (pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_spike_count (rsp_spike_count),
      .rsp_ready_res   (rsp_ready_res)
   );
endmodule

### rtl/wca_checker.sv
// ----------------------------------------------------------------------------
// wca_checker
// Port-level checks of the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module wca_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid
);
   // clearing pass holds off commands right after reset
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   a_quiet_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result straight after reset");

   // the back never strobes two results back to back
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in consecutive cycles");
endmodule

bind waveform_covariance_accumulator wca_checker u_wca_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

### tb/waveform_covariance_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_covariance_accumulator_tb
// Drives sample and read commands through the start/busy port, predicts every
// result from a behavioural copy of the statistics stores and compares each
// strobed result in order. A directed table comes first, then random spike
// waveforms and noise under several scale and threshold settings.
// ----------------------------------------------------------------------------
module waveform_covariance_accumulator_tb;

   localparam longint CYCLE_LIMIT = 8_000_000;
   localparam int     RAND_ITEMS  = 1600;
   localparam int     DRAIN_WAIT  = 1400;

   typedef struct packed {
      logic               command;
      logic [5:0]         channel;
      logic [3:0]         tetrode;
      logic [4:0]         row;
      logic [4:0]         col;
      logic signed [15:0] value;
      logic               accumulate;
      logic               spike_end;
      logic [1:0]         sel;
   } cmd_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [23:0]        count;
      logic               ready;
   } stat_result_type;

   typedef struct packed {
      cmd_type         cmd;
      logic            typed;
      stat_result_type res;
   } table_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_command;
   logic [5:0]         req_channel;
   logic [3:0]         req_tetrode;
   logic [4:0]         req_sample_index;
   logic [4:0]         req_column_index;
   logic signed [15:0] req_sample_value;
   logic               req_accumulate;
   logic               req_spike_end;
   logic [1:0]         req_read_select;
   logic               rsp_valid;
   logic signed [31:0] rsp_read_value;
   logic [23:0]        rsp_spike_count;
   logic               rsp_ready_res;
   logic               csr_write_enable;
   logic               csr_index;
   logic [15:0]        csr_write_data;

   waveform_covariance_accumulator dut (.*);

   // predictor state
   logic [12:0] scale_reg;
   logic [15:0] min_count_reg;
   int          wave_buf [wca_pkg::SAMPLES];
   int          mean_sum [wca_pkg::CHANNELS*wca_pkg::SAMPLES];
   int          square_sum [wca_pkg::CHANNELS*wca_pkg::SAMPLES];
   int          cov_sum [wca_pkg::CHANNELS*wca_pkg::SAMPLES*wca_pkg::SAMPLES];
   logic [23:0] spike_cnt [wca_pkg::TETRODES];

   stat_result_type pending_results [$];
   table_row_type   directed_rows [$];
   logic [wca_pkg::SAMPLES-1:0] buf_written;
   int  errors, n_acc, n_read, n_phases, n_results;
   longint cycle_count;
   logic start_high;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int sat32(input longint acc, input longint delta);
      longint s;
      s = acc + delta;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return int'(s);
   endfunction

   function automatic stat_result_type predict_stats(input cmd_type c);
      stat_result_type res;
      longint smp, scl, q, p;
      int base, r, k;
      res = '0;
      smp = c.value;
      scl = (scale_reg == 0) ? 1 : scale_reg;
      base = c.channel * wca_pkg::SAMPLES;
      if (c.command == wca_pkg::CMD_ACC) begin
         wave_buf[c.row] = c.value;
         if (c.accumulate) begin
            q = smp / scl;
            mean_sum[base+c.row] = sat32(mean_sum[base+c.row], q);
            square_sum[base+c.row] = sat32(square_sum[base+c.row], (q * smp) / scl);
            for (int w = 0; w <= c.row; w++) begin
               k = (base + w) * wca_pkg::SAMPLES + c.row;
               p = longint'(wave_buf[w]) * smp;
               cov_sum[k] = sat32(cov_sum[k], p / (scl * scl));
            end
         end
         if (c.spike_end && spike_cnt[c.tetrode] != wca_pkg::COUNT_MAX)
            spike_cnt[c.tetrode] = spike_cnt[c.tetrode] + 1;
      end else begin
         case (c.sel)
            wca_pkg::SEL_COV: begin
               r = (c.col < c.row) ? c.col : c.row;
               k = (c.col < c.row) ? c.row : c.col;
               res.value = cov_sum[(base + r) * wca_pkg::SAMPLES + k];
            end
            wca_pkg::SEL_MEAN: res.value = mean_sum[base+c.row];
            wca_pkg::SEL_SQ:   res.value = square_sum[base+c.row];
            default:           res.value = 0;
         endcase
      end
      res.count = spike_cnt[c.tetrode];
      res.ready = (spike_cnt[c.tetrode] >= min_count_reg);
      return res;
   endfunction

   // checker: results are taken at the edge that ends their strobe cycle
   always @(posedge clock) begin
      stat_result_type e;
      if (!reset && rsp_valid) begin
         n_results++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result value=%0d count=%0d ready=%0d",
                     $time, rsp_read_value, rsp_spike_count, rsp_ready_res);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_read_value !== e.value) begin
               $display("%0t: read_value expected %0d actual %0d", $time, e.value,
                        rsp_read_value);
               errors++;
            end
            if (rsp_spike_count !== e.count) begin
               $display("%0t: spike_count expected %0d actual %0d", $time, e.count,
                        rsp_spike_count);
               errors++;
            end
            if (rsp_ready_res !== e.ready) begin
               $display("%0t: ready_res expected %0d actual %0d", $time, e.ready,
                        rsp_ready_res);
               errors++;
            end
         end
      end
   end

   // hands one command over; start stays high when the next has no gap
   task automatic send_cmd(input cmd_type c, input logic typed,
                           input stat_result_type typed_res);
      int gap;
      stat_result_type res;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0 && start_high) begin
         start <= 1'b0;
         start_high = 1'b0;
         repeat (gap) @(posedge clock);
      end else if (gap > 0) begin
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      start_high = 1'b1;
      req_command <= c.command;
      req_channel <= c.channel;
      req_tetrode <= c.tetrode;
      req_sample_index <= c.row;
      req_column_index <= c.col;
      req_sample_value <= c.value;
      req_accumulate <= c.accumulate;
      req_spike_end <= c.spike_end;
      req_read_select <= c.sel;
      do @(posedge clock); while (busy);
      // transfer happened at this edge
      res = predict_stats(c);
      pending_results.push_back(typed ? typed_res : res);
      if (c.command == wca_pkg::CMD_ACC) n_acc++;
      else n_read++;
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      if (idx == wca_pkg::REG_SCALE) scale_reg = data[12:0];
      else min_count_reg = data;
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_idle();
      if (start_high) begin
         start <= 1'b0;
         start_high = 1'b0;
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic cmd_type make_read();
      cmd_type c;
      c = '0;
      c.command = wca_pkg::CMD_READ;
      c.channel = 6'($urandom);
      c.tetrode = 4'($urandom);
      c.row = 5'($urandom);
      c.col = 5'($urandom);
      c.value = 16'($urandom);
      c.accumulate = 1'($urandom);
      c.spike_end = 1'($urandom);
      c.sel = 2'($urandom);
      return c;
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic table_row_type row_of(input logic cmd, input int ch, input int tet,
                                            input int r, input int col, input int val,
                                            input logic acc, input logic se,
                                            input logic [1:0] sel, input logic typed,
                                            input int ev, input int ec, input logic er);
      table_row_type t;
      t.cmd = '{cmd, ch[5:0], tet[3:0], r[4:0], col[4:0], val[15:0], acc, se, sel};
      t.typed = typed;
      t.res = '{ev, ec[23:0], er};
      return t;
   endfunction

   initial begin
      cmd_type c;
      int sent, len, ch, tet;
      logic acc;
      clock = 1'b0;
      errors = 0; n_acc = 0; n_read = 0; n_phases = 0; n_results = 0;
      cycle_count = 0;
      start_high = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_command = wca_pkg::CMD_ACC;
      req_channel = '0;
      req_tetrode = '0;
      req_sample_index = '0;
      req_column_index = '0;
      req_sample_value = '0;
      req_accumulate = 1'b0;
      req_spike_end = 1'b0;
      req_read_select = wca_pkg::SEL_COV;
      csr_write_enable = 1'b0;
      csr_index = wca_pkg::REG_SCALE;
      csr_write_data = '0;
      scale_reg = 13'd1;
      min_count_reg = 16'd1000;
      buf_written = '0;
      foreach (wave_buf[i]) wave_buf[i] = 0;
      foreach (mean_sum[i]) begin
         mean_sum[i] = 0;
         square_sum[i] = 0;
      end
      foreach (cov_sum[i]) cov_sum[i] = 0;
      foreach (spike_cnt[i]) spike_cnt[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table: reads after reset, extremes, swap, unused select
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0,
                                     wca_pkg::SEL_COV, 1, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 63, 15, 31, 31, 0, 0, 0,
                                     wca_pkg::SEL_MEAN, 1, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 63, 15, 31, 0, -1, 1, 1,
                                     wca_pkg::SEL_SQ, 1, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 5, 0, 0, 0, 0, 0, 0,
                                     2'd3, 1, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_ACC, 5, 3, 0, 0, 32767, 1, 0,
                                     wca_pkg::SEL_COV, 0, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_ACC, 5, 3, 1, 0, -32768, 1, 0,
                                     wca_pkg::SEL_COV, 0, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_ACC, 5, 3, 2, 0, -1, 1, 1,
                                     wca_pkg::SEL_COV, 0, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 5, 3, 2, 0, 0, 0, 0,
                                     wca_pkg::SEL_COV, 0, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 5, 3, 0, 2, 0, 0, 0,
                                     wca_pkg::SEL_COV, 0, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 5, 3, 1, 1, 0, 0, 0,
                                     wca_pkg::SEL_COV, 0, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 5, 3, 1, 0, 0, 0, 0,
                                     wca_pkg::SEL_MEAN, 0, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 5, 3, 0, 0, 0, 0, 0,
                                     wca_pkg::SEL_SQ, 0, 0, 0, 0));
      // square sum of the same extreme twice saturates
      directed_rows.push_back(row_of(wca_pkg::CMD_ACC, 5, 3, 0, 0, -32768, 1, 0,
                                     wca_pkg::SEL_COV, 0, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_ACC, 5, 3, 0, 0, -32768, 1, 0,
                                     wca_pkg::SEL_COV, 0, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 5, 3, 0, 0, 0, 0, 0,
                                     wca_pkg::SEL_SQ, 1, 2147483647, 1, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 5, 3, 0, 0, 0, 0, 0,
                                     wca_pkg::SEL_COV, 1, 2147483647, 1, 0));
      // count only, and spike end ignored on reads
      directed_rows.push_back(row_of(wca_pkg::CMD_ACC, 63, 15, 31, 0, 1234, 0, 1,
                                     wca_pkg::SEL_COV, 0, 0, 0, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 63, 15, 31, 0, 0, 0, 1,
                                     wca_pkg::SEL_MEAN, 1, 0, 1, 0));
      directed_rows.push_back(row_of(wca_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0,
                                     wca_pkg::SEL_COV, 1, 0, 0, 0));
      for (int i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].cmd.command == wca_pkg::CMD_ACC)
            buf_written[directed_rows[i].cmd.row] = 1'b1;
         send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
      end
      wait_idle();

      // threshold reached at once, then zero scale
      write_reg(wca_pkg::REG_MIN, 16'd1);
      write_reg(wca_pkg::REG_SCALE, 16'd0);
      send_cmd(row_of(wca_pkg::CMD_READ, 0, 3, 0, 0, 0, 0, 0, wca_pkg::SEL_MEAN,
                      0, 0, 0, 0).cmd, 1'b0, '0);
      send_cmd(row_of(wca_pkg::CMD_ACC, 7, 0, 0, 0, -32768, 1, 1, wca_pkg::SEL_COV,
                      0, 0, 0, 0).cmd, 1'b0, '0);
      wait_idle();

      sent = 0;
      for (int ph = 0; ph < 6; ph++) begin
         n_phases++;
         case (ph)
            0: begin
               write_reg(wca_pkg::REG_SCALE, 16'd1);
               write_reg(wca_pkg::REG_MIN, 16'd65535);
            end
            1: begin
               write_reg(wca_pkg::REG_SCALE, 16'd4096);
               write_reg(wca_pkg::REG_MIN, 16'd1);
            end
            2: begin
               write_reg(wca_pkg::REG_SCALE, 16'd0);
               write_reg(wca_pkg::REG_MIN, 16'd3);
            end
            3: begin
               write_reg(wca_pkg::REG_SCALE, 16'($urandom_range(2, 64)));
               write_reg(wca_pkg::REG_MIN, 16'($urandom_range(1, 40)));
            end
            4: begin
               write_reg(wca_pkg::REG_SCALE, 16'($urandom_range(1, 4096)));
               write_reg(wca_pkg::REG_MIN, 16'($urandom));
            end
            default: begin
               write_reg(wca_pkg::REG_SCALE, 16'h1FFF);
               write_reg(wca_pkg::REG_MIN, 16'd20);
            end
         endcase
         while (sent < (ph + 1) * RAND_ITEMS / 6) begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  c = make_read();
                  send_cmd(c, 1'b0, '0);
                  sent++;
               end
               2: begin
                  // noise: accumulation only where the earlier samples exist
                  c = make_read();
                  c.command = wca_pkg::CMD_ACC;
                  c.value = pick_sample();
                  for (int w = 0; w < c.row; w++)
                     if (!buf_written[w]) c.accumulate = 1'b0;
                  buf_written[c.row] = 1'b1;
                  send_cmd(c, 1'b0, '0);
                  sent++;
               end
               default: begin
                  // a well-formed waveform, mostly short
                  len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 32)
                                                     : $urandom_range(1, 6);
                  ch = $urandom_range(0, 63);
                  tet = $urandom_range(0, 15);
                  acc = ($urandom_range(0, 7) != 0);
                  for (int r = 0; r < len; r++) begin
                     c = make_read();
                     c.command = wca_pkg::CMD_ACC;
                     c.channel = 6'(ch);
                     c.tetrode = 4'(tet);
                     c.row = 5'(r);
                     c.value = pick_sample();
                     c.accumulate = acc;
                     c.spike_end = (r == len - 1);
                     buf_written[r] = 1'b1;
                     send_cmd(c, 1'b0, '0);
                     sent++;
                  end
               end
            endcase
         end
         wait_idle();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d sample and %0d read transfers, %0d results, %0d register phases",
               n_acc, n_read, n_results, n_phases);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, pending_results.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/wca_pkg.sv
rtl/wca_divider.sv
rtl/wca_front.sv
rtl/wca_fifo.sv
rtl/wca_back.sv
rtl/waveform_covariance_accumulator.sv
rtl/wca_checker.sv
tb/waveform_covariance_accumulator_tb.sv
